/* hdl/itw_pkg.sv */
// Shared types and constants for the idle-connection timing wheel.
package itw_pkg;

    localparam int ID_W             = 16;
    localparam int SLOT_MW          = 8;   // slot field in the packet, fits up to 256 slots
    localparam int IDX_MW           = 6;   // entry index field in the packet, fits up to 64 cells
    localparam int TDATA_W          = 24;
    localparam int WHEEL_SLOTS_DEF  = 16;
    localparam int POOL_ENTRIES_DEF = 32;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_REFRESH = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_DONE      = 2'd0,
        KIND_NOT_FOUND = 2'd1,
        KIND_FULL      = 2'd2,
        KIND_CLOSE     = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Command packet that walks the cell chain, one cell per cycle while the result output is not stalled.
    typedef struct packed {
        logic              vld;
        cmd_t              op;
        logic              apply;    // second pass: commit the chosen entries
        logic [ID_W-1:0]   id;
        logic [SLOT_MW-1:0] cur;     // current slot
        logic [SLOT_MW-1:0] tgt;     // best key so far, or expiring slot on tick
        logic              hit;
        logic [IDX_MW-1:0] hit_idx;
        logic              fr;
        logic [IDX_MW-1:0] fr_idx;
    } pkt_t;

endpackage

/* hdl/idle_connection_timing_wheel.sv */
// Top level of the idle-connection timing wheel: command sequencer and cell chain.
//
//  channel | dir | handshake        | tdata fields (low bit up)          | tuser
//  s_      | in  | s_tvalid/tready  | cmd[1:0], conn_id[17:2]            | -
//  m_      | out | m_tvalid/tready  | kind[1:0], result_conn[17:2], tlast| -
//
// A command packet walks the chain of POOL_ENTRIES cells, one cell per cycle.
// Tick takes one pass; closes leave as the packet passes. Add, refresh and remove
// take a search pass and, when an entry changes, a commit pass.
// Reset clears every entry mark and the current slot at once.
// A stalled result freezes the whole chain until m_tready rises.
module idle_connection_timing_wheel #(
    parameter int WHEEL_SLOTS  = itw_pkg::WHEEL_SLOTS_DEF,
    parameter int POOL_ENTRIES = itw_pkg::POOL_ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [itw_pkg::TDATA_W-1:0] s_tdata,  // cmd, conn_id
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [itw_pkg::TDATA_W-1:0] m_tdata,  // kind, result_conn
    output logic                       m_tlast
);
    import itw_pkg::*;

    localparam int SLOT_W = $clog2(WHEEL_SLOTS);

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    pkt_t              tail_reg;
    logic              m_valid_reg, m_valid_next;
    kind_t             m_kind_reg, m_kind_next;
    logic [ID_W-1:0]   m_conn_reg, m_conn_next;
    logic              m_last_reg, m_last_next;

    pkt_t              head_pkt;
    pkt_t              chain [POOL_ENTRIES+1];
    logic              emit_vec [POOL_ENTRIES];
    logic [ID_W-1:0]   emit_conn [POOL_ENTRIES];

    logic              step;
    logic              accept;
    logic              need_apply;
    logic              finish;
    logic              any_emit;
    logic [ID_W-1:0]   emit_c;
    cmd_t              in_cmd;
    logic [ID_W-1:0]   in_id;
    logic [SLOT_W-1:0] cur_plus;
    logic [SLOT_W-1:0] cur_plus2;
    kind_t             fin_kind;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] x);
        slot_inc = (x == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : x + 1'b1;
    endfunction

    assign step      = !m_valid_reg || m_tready;
    assign in_cmd    = cmd_t'(s_tdata[1:0]);
    assign in_id     = s_tdata[ID_W+1:2];
    assign cur_plus  = slot_inc(cur_reg);
    assign cur_plus2 = slot_inc(cur_plus);
    assign chain[0]  = head_pkt;

    // Cell chain
    for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
        itw_cell #(
            .SLOTS (WHEEL_SLOTS),
            .IDX   (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (step),
            .pkt_in    (chain[i]),
            .pkt_out   (chain[i+1]),
            .emit      (emit_vec[i]),
            .emit_conn (emit_conn[i])
        );
    end

    // Gather the close raised by the cell that holds the tick packet
    always_comb begin
        any_emit = 1'b0;
        emit_c   = '0;
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            any_emit = any_emit | emit_vec[i];
            emit_c   = emit_c | (emit_vec[i] ? emit_conn[i] : '0);
        end
    end

    // Decide on the packet leaving the chain
    always_comb begin
        need_apply = 1'b0;
        fin_kind   = KIND_DONE;
        case (tail_reg.op)
            CMD_ADD: begin
                need_apply = !tail_reg.apply && tail_reg.fr;
                fin_kind   = tail_reg.apply ? KIND_DONE : KIND_FULL;
            end
            CMD_REFRESH: begin
                need_apply = !tail_reg.apply && tail_reg.hit && tail_reg.fr;
                if (tail_reg.apply) begin
                    fin_kind = KIND_DONE;
                end else if (!tail_reg.hit) begin
                    fin_kind = KIND_NOT_FOUND;
                end else begin
                    fin_kind = KIND_FULL;
                end
            end
            CMD_REMOVE: begin
                need_apply = !tail_reg.apply && tail_reg.hit;
                fin_kind   = tail_reg.apply ? KIND_CLOSE : KIND_NOT_FOUND;
            end
            default: begin
                need_apply = 1'b0;
                fin_kind   = KIND_DONE;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && step) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (tail_reg.vld && step && !need_apply) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: launch packets, load results, advance the wheel
    always_comb begin
        s_tready     = 1'b0;
        finish       = 1'b0;
        head_pkt     = '0;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_conn_next  = m_conn_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = step;
                head_pkt.vld = 1'b1;
                head_pkt.op  = in_cmd;
                head_pkt.id  = in_id;
                if (in_cmd == CMD_TICK) begin
                    head_pkt.cur = SLOT_MW'(cur_plus);
                    head_pkt.tgt = SLOT_MW'(cur_plus2);
                end else begin
                    head_pkt.cur = SLOT_MW'(cur_reg);
                end
            end
            ST_RUN: begin
                if (tail_reg.vld && need_apply) begin
                    head_pkt       = tail_reg;
                    head_pkt.apply = 1'b1;
                end
                finish = tail_reg.vld && !need_apply;
            end
            default: s_tready = 1'b0;
        endcase
        if (state_reg == ST_IDLE && !s_tvalid) begin
            head_pkt.vld = 1'b0;
        end
        if (s_tready && s_tvalid && in_cmd == CMD_TICK) begin
            cur_next = cur_plus;
        end
        if (step && any_emit) begin
            m_valid_next = 1'b1;
            m_kind_next  = KIND_CLOSE;
            m_conn_next  = emit_c;
            m_last_next  = 1'b0;
        end else if (step && finish) begin
            m_valid_next = 1'b1;
            m_kind_next  = fin_kind;
            m_conn_next  = tail_reg.id;
            m_last_next  = 1'b1;
        end
    end

    assign accept = s_tvalid && s_tready;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                cur_reg <= cur_next;
            end
            if (step) begin
                tail_reg <= chain[POOL_ENTRIES];
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_conn_reg <= m_conn_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(TDATA_W - ID_W - 2)'(0), m_conn_reg, m_kind_reg};

endmodule

/* hdl/itw_cell.sv */
// One pool entry of the wheel: holds its entry and acts on the passing packet.
module itw_cell #(
    parameter int SLOTS = itw_pkg::WHEEL_SLOTS_DEF,
    parameter int IDX   = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  itw_pkg::pkt_t           pkt_in,
    output itw_pkg::pkt_t           pkt_out,
    output logic                    emit,
    output logic [itw_pkg::ID_W-1:0] emit_conn
);
    import itw_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [IDX_MW-1:0] MY_IDX = IDX_MW'(IDX);

    pkt_t              pkt_reg, pkt_next;
    logic [ID_W-1:0]   conn_reg, conn_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              alive_reg, alive_next;
    logic              used_reg, used_next;

    logic [SLOT_MW-1:0] slot_x;
    logic [SLOT_MW-1:0] gap;
    logic [SLOT_MW-1:0] key;
    logic               match;
    logic               cand;

    // Search, expire or commit against the packet held in this cell
    always_comb begin
        pkt_next   = pkt_in;
        pkt_out    = pkt_reg;
        conn_next  = conn_reg;
        slot_next  = slot_reg;
        alive_next = alive_reg;
        used_next  = used_reg;
        emit       = 1'b0;
        emit_conn  = conn_reg;

        slot_x = SLOT_MW'(slot_reg);
        if (slot_x >= pkt_reg.cur) begin
            gap = slot_x - pkt_reg.cur;
        end else begin
            gap = slot_x + SLOT_MW'(SLOTS) - pkt_reg.cur;
        end
        match = used_reg && alive_reg && (conn_reg == pkt_reg.id);
        cand  = 1'b0;
        key   = slot_x;
        if (pkt_reg.op == CMD_REFRESH) begin
            cand = match && (slot_x != pkt_reg.cur);
            key  = gap;
        end else if (pkt_reg.op == CMD_REMOVE) begin
            cand = match;
        end

        if (pkt_reg.vld) begin
            if (pkt_reg.op == CMD_TICK) begin
                if (used_reg && slot_x == pkt_reg.tgt) begin
                    emit       = alive_reg;
                    alive_next = 1'b0;
                    used_next  = 1'b0;
                end
            end else if (!pkt_reg.apply) begin
                if (cand && (!pkt_reg.hit || key < pkt_reg.tgt)) begin
                    pkt_out.hit     = 1'b1;
                    pkt_out.hit_idx = MY_IDX;
                    pkt_out.tgt     = key;
                end
                if (!used_reg && !pkt_reg.fr) begin
                    pkt_out.fr     = 1'b1;
                    pkt_out.fr_idx = MY_IDX;
                end
            end else begin
                if (pkt_reg.fr && pkt_reg.fr_idx == MY_IDX && pkt_reg.op != CMD_REMOVE) begin
                    conn_next  = pkt_reg.id;
                    slot_next  = pkt_reg.cur[SLOT_W-1:0];
                    alive_next = 1'b1;
                    used_next  = 1'b1;
                end
                if (pkt_reg.hit && pkt_reg.hit_idx == MY_IDX && pkt_reg.op != CMD_ADD) begin
                    alive_next = 1'b0;
                end
            end
        end
    end

    // Advance the packet and commit entry marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_reg   <= '0;
            alive_reg <= 1'b0;
            used_reg  <= 1'b0;
        end else if (step) begin
            pkt_reg   <= pkt_next;
            alive_reg <= alive_next;
            used_reg  <= used_next;
        end
    end

    // Hold entry payload
    always_ff @(posedge aclk) begin
        if (step) begin
            conn_reg <= conn_next;
            slot_reg <= slot_next;
        end
    end

endmodule

/* hdl/itw_checker.sv */
// Port-level checks for the idle-connection timing wheel, bound to the top level.
module itw_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [itw_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic                        m_tlast
);
    import itw_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A stalled result blocks new commands
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("command accepted under output stall");

    // One command at a time
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while busy");

    // Only a close may be followed by more results
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != KIND_CLOSE |-> m_tlast)
        else $error("non-close result without tlast");

endmodule

bind idle_connection_timing_wheel itw_checker u_itw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);
